### sv/atp_pkg.sv
// Shared types and constants for the two-level aging task picker.
// Used by atp_ager and aging_two_level_task_picker; no dependencies.
`default_nettype none

package atp_pkg;

  // Sizing
  localparam int NUM_PROCESSES       = 16;
  localparam int THREADS_PER_PROCESS = 8;
  localparam int IDLE_WIDTH          = 16;

  localparam int THR_TOTAL = NUM_PROCESSES * THREADS_PER_PROCESS;
  localparam int PID_W     = $clog2(NUM_PROCESSES);
  localparam int TID_W     = (THREADS_PER_PROCESS > 1) ? $clog2(THREADS_PER_PROCESS) : 1;
  localparam int TADDR_W   = $clog2(THR_TOTAL);
  localparam int IDX_W     = (PID_W > TID_W) ? PID_W : TID_W;
  localparam int WALK_MAX  = (NUM_PROCESSES > THREADS_PER_PROCESS) ?
                             NUM_PROCESSES : THREADS_PER_PROCESS;
  localparam int CNT_W     = $clog2(WALK_MAX + 1);

  localparam logic [IDLE_WIDTH-1:0] IDLE_MAX = {IDLE_WIDTH{1'b1}};

  // Thread memory word: status bits and idle count
  localparam int THR_ENTRY_W = IDLE_WIDTH + 2;

  // Command codes
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_EXIT   = 2'd2
  } mode_t;

  // Command and result payloads
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] proc_id;
    logic [2:0] thread_id;
  } cmd_t;

  typedef struct packed {
    logic       switched;
    logic [3:0] next_process;
    logic [2:0] pick_thread;
    logic       fell_back;
  } result_t;

  // One thread entry as held in the thread memory
  typedef struct packed {
    logic                  valid;
    logic                  waiting;
    logic [IDLE_WIDTH-1:0] idle;
  } thr_entry_t;

  // Control into the aging/compare unit
  typedef struct packed {
    logic             clr;
    logic             hit;
    logic             waiting;
    logic [IDX_W-1:0] idx;
  } ager_ctl_t;

  // Running best of the aging/compare unit
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] best_idx;
  } ager_stat_t;

endpackage

`default_nettype wire

### sv/aging_two_level_task_picker.sv
// Two-level aging task picker. A command transfer happens on a clock edge with
// start high and busy low; its result appears on result for exactly one cycle
// with done high, and must be taken then since the receiver cannot stall it.
// After reset busy stays high while the thread memory is cleared. Create, unused
// commands and an exit with nothing running keep busy low, and done follows on
// the next cycle. An exit of a running process holds busy while it clears its
// thread entries, one per cycle, and done follows. A reschedule tick holds busy
// because the process counts and the thread entries sit in two memories with
// one read port each, walked one entry per cycle: all processes, then the
// threads of the chosen process, then a commit state. A tick with nothing to
// pick and nothing running ends after the process walk. Every command gives one
// result.
// Depends on atp_pkg, atp_ram and atp_ager.
`default_nettype none

module aging_two_level_task_picker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire atp_pkg::cmd_t    cmd,
  output logic                  done,
  output atp_pkg::result_t      result
);

  import atp_pkg::*;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_PROC = 7'b0000100,
    S_PDEC = 7'b0001000,
    S_THR  = 7'b0010000,
    S_TDEC = 7'b0100000,
    S_EXIT = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0]   PROC_END = CNT_W'(NUM_PROCESSES);
  localparam logic [CNT_W-1:0]   THR_END  = CNT_W'(THREADS_PER_PROCESS);
  localparam logic [CNT_W-1:0]   EXIT_END = CNT_W'(THREADS_PER_PROCESS - 1);
  localparam logic [TADDR_W-1:0] INIT_END = TADDR_W'(THR_TOTAL - 1);

  state_t state;

  // Process status in flops, thread status and all idle counts in memories
  logic [NUM_PROCESSES-1:0] proc_valid;
  logic [NUM_PROCESSES-1:0] proc_waiting;
  logic                     cur_valid;
  logic [PID_W-1:0]         cur_process;
  logic [TID_W-1:0]         cur_thread;

  // Walk control
  logic [CNT_W-1:0]   idx;
  logic [TADDR_W-1:0] init_addr;
  logic               pend;
  logic [IDX_W-1:0]   pidx;
  logic [PID_W-1:0]   np;
  logic [TADDR_W-1:0] base;
  logic               fell;
  logic               slot_valid;

  // Memory ports
  logic                  p_we;
  logic [PID_W-1:0]      p_waddr;
  logic [PID_W-1:0]      p_raddr;
  logic [IDLE_WIDTH-1:0] p_wdata;
  logic [IDLE_WIDTH-1:0] p_rdata;
  logic                  t_we;
  logic [TADDR_W-1:0]    t_waddr;
  logic [TADDR_W-1:0]    t_raddr;
  thr_entry_t            t_wdata;
  thr_entry_t            t_rdata;

  ager_ctl_t             actl;
  ager_stat_t            astat;
  logic [IDLE_WIDTH-1:0] bumped;

  logic               accept;
  logic [PID_W-1:0]   c_pid;
  logic [TID_W-1:0]   c_tid;
  logic [TADDR_W-1:0] c_taddr;
  logic               c_ok;
  logic [PID_W-1:0]   walk_pid;
  logic [TADDR_W-1:0] walk_taddr;
  logic [TADDR_W-1:0] cur_taddr;
  logic [TADDR_W-1:0] cur_base;
  logic [PID_W-1:0]   np_sel;
  logic               pdec_abort;
  logic [TID_W-1:0]   nt_sel;
  logic [TADDR_W-1:0] nt_taddr;
  logic               nt_valid;
  logic               tdec_abort;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Address arithmetic
  always_comb begin
    c_pid      = PID_W'(cmd.proc_id);
    c_tid      = TID_W'(cmd.thread_id);
    c_taddr    = TADDR_W'(c_pid * THREADS_PER_PROCESS + c_tid);
    c_ok       = (32'(cmd.proc_id) < NUM_PROCESSES) &&
                 (32'(cmd.thread_id) < THREADS_PER_PROCESS) &&
                 !(cur_valid && c_pid == cur_process && c_tid == cur_thread);
    walk_pid   = PID_W'(pidx);
    walk_taddr = base + TADDR_W'(pidx);
    cur_base   = TADDR_W'(cur_process * THREADS_PER_PROCESS);
    cur_taddr  = cur_base + TADDR_W'(cur_thread);
  end

  // Level decisions
  always_comb begin
    np_sel     = astat.found ? PID_W'(astat.best_idx) : cur_process;
    pdec_abort = !astat.found && !cur_valid;
    nt_sel     = astat.found ? TID_W'(astat.best_idx) : cur_thread;
    nt_taddr   = base + TADDR_W'(nt_sel);
    nt_valid   = astat.found || slot_valid;
    tdec_abort = !astat.found && !cur_valid;
  end

  // Aging unit control; the running thread keeps its stored waiting bit set
  // and is masked here, so it reads as waiting again once it stops running
  always_comb begin
    actl.clr     = (accept && cmd.mode == MODE_TICK) || (state == S_PDEC);
    actl.idx     = pidx;
    actl.hit     = 1'b0;
    actl.waiting = 1'b0;
    if (state == S_PROC) begin
      actl.hit     = pend && proc_valid[walk_pid];
      actl.waiting = proc_waiting[walk_pid];
    end else if (state == S_THR) begin
      actl.hit     = pend && t_rdata.valid;
      actl.waiting = t_rdata.waiting && !(cur_valid && walk_taddr == cur_taddr);
    end
  end

  atp_ager u_ager (
    .clk    (clk),
    .rst    (rst),
    .ctl    (actl),
    .cnt    ((state == S_PROC) ? p_rdata : t_rdata.idle),
    .bumped (bumped),
    .stat   (astat)
  );

  // Memory read addresses follow the walk counter
  always_comb begin
    p_raddr = PID_W'(idx);
    t_raddr = base + TADDR_W'(idx);
  end

  // Memory writes: clearing pass, aging write-back, create, commit, exit
  always_comb begin
    p_we            = 1'b0;
    p_waddr         = walk_pid;
    p_wdata         = bumped;
    t_we            = 1'b0;
    t_waddr         = walk_taddr;
    t_wdata.valid   = t_rdata.valid;
    t_wdata.waiting = t_rdata.waiting;
    t_wdata.idle    = bumped;
    case (state)
      S_INIT: begin
        t_we    = 1'b1;
        t_waddr = init_addr;
        t_wdata = '0;
      end
      S_IDLE: begin
        if (accept && cmd.mode == MODE_CREATE && c_ok) begin
          p_we            = !proc_valid[c_pid];
          p_waddr         = c_pid;
          p_wdata         = '0;
          t_we            = 1'b1;
          t_waddr         = c_taddr;
          t_wdata.valid   = 1'b1;
          t_wdata.waiting = 1'b1;
          t_wdata.idle    = '0;
        end
      end
      S_PROC: begin
        p_we = actl.hit;
      end
      S_THR: begin
        t_we = actl.hit;
      end
      S_TDEC: begin
        if (!tdec_abort) begin
          p_we            = 1'b1;
          p_waddr         = np;
          p_wdata         = '0;
          t_we            = 1'b1;
          t_waddr         = nt_taddr;
          t_wdata.valid   = nt_valid;
          t_wdata.waiting = 1'b1;
          t_wdata.idle    = '0;
        end
      end
      S_EXIT: begin
        t_we    = 1'b1;
        t_waddr = cur_base + TADDR_W'(idx);
        t_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  atp_ram #(.WIDTH(IDLE_WIDTH), .DEPTH(NUM_PROCESSES)) u_proc_idle (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  atp_ram #(.WIDTH(THR_ENTRY_W), .DEPTH(THR_TOTAL)) u_thr_entry (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Sequencer and status state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      proc_valid   <= '0;
      proc_waiting <= '0;
      cur_valid    <= 1'b0;
      cur_process  <= '0;
      cur_thread   <= '0;
      pend         <= 1'b0;
      idx          <= '0;
      init_addr    <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          if (init_addr == INIT_END) begin
            state <= S_IDLE;
          end else begin
            init_addr <= init_addr + TADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (cmd.mode)
              MODE_TICK: begin
                state <= S_PROC;
                idx   <= '0;
                pend  <= 1'b0;
              end
              MODE_CREATE: begin
                done <= 1'b1;
                if (c_ok && !proc_valid[c_pid]) begin
                  proc_valid[c_pid]   <= 1'b1;
                  proc_waiting[c_pid] <= 1'b1;
                end
              end
              MODE_EXIT: begin
                if (cur_valid) begin
                  proc_valid[cur_process]   <= 1'b0;
                  proc_waiting[cur_process] <= 1'b0;
                  cur_valid                 <= 1'b0;
                  state                     <= S_EXIT;
                  idx                       <= '0;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_PROC: begin
          pend <= (idx != PROC_END);
          if (idx == PROC_END) begin
            state <= S_PDEC;
            idx   <= '0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_PDEC: begin
          pend <= 1'b0;
          idx  <= '0;
          if (pdec_abort) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_THR;
          end
        end
        S_THR: begin
          pend <= (idx != THR_END);
          if (idx == THR_END) begin
            state <= S_TDEC;
            idx   <= '0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_TDEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
          pend  <= 1'b0;
          if (!tdec_abort) begin
            if (cur_valid) begin
              proc_waiting[cur_process] <= 1'b1;
            end
            proc_waiting[np] <= 1'b0;
            cur_valid        <= 1'b1;
            cur_process      <= np;
            cur_thread       <= nt_sel;
          end
        end
        // Clear the exiting process's thread entries, one per cycle
        S_EXIT: begin
          if (idx == EXIT_END) begin
            state <= S_IDLE;
            done  <= 1'b1;
            idx   <= '0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Walk payload: entry index in flight, chosen process and its thread base,
  // and the valid bit of the current thread's slot in the chosen process
  always_ff @(posedge clk) begin
    pidx <= IDX_W'(idx);
    if (state == S_IDLE) begin
      fell <= 1'b0;
    end else if (state == S_PDEC) begin
      np   <= np_sel;
      base <= TADDR_W'(np_sel * THREADS_PER_PROCESS);
      fell <= !astat.found;
    end
    if (state == S_PDEC) begin
      slot_valid <= 1'b0;
    end else if (state == S_THR && pend && TID_W'(pidx) == cur_thread) begin
      slot_valid <= t_rdata.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_TDEC && !tdec_abort) begin
      result.switched     <= 1'b1;
      result.next_process <= 4'(np);
      result.pick_thread  <= 3'(nt_sel);
      result.fell_back    <= fell || !astat.found;
    end else begin
      result <= '0;
    end
  end

`ifndef SYNTHESIS
  // A command ends only with its result; the clearing pass has none
  a_busy_end_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && $past(state) != S_INIT) |-> done)
    else $error("busy dropped without a result");

  // Every command either starts a walk or reports on the next cycle
  a_accept_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command neither walking nor reported");

  // A switch leaves something running
  a_switch_running: assert property (@(posedge clk) disable iff (rst)
    (done && result.switched) |-> cur_valid)
    else $error("switch reported with nothing running");

  // No switch reports all-zero fields
  a_noswitch_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.switched) |->
      (!result.fell_back && result.next_process == 4'd0 && result.pick_thread == 3'd0))
    else $error("non-switch result carries data");
`endif

endmodule

`default_nettype wire

### sv/atp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module atp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/atp_ager.sv
// Aging and oldest-waiting search unit, shared by the process and thread walks.
// Depends on atp_pkg.
`default_nettype none

module atp_ager (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire atp_pkg::ager_ctl_t             ctl,
  input  wire logic [atp_pkg::IDLE_WIDTH-1:0] cnt,
  output logic      [atp_pkg::IDLE_WIDTH-1:0] bumped,
  output atp_pkg::ager_stat_t                 stat
);

  import atp_pkg::*;

  logic [IDLE_WIDTH-1:0] best_cnt;
  logic                  take;

  // Saturating increment and strict compare: first index wins a tie
  always_comb begin
    bumped = (cnt == IDLE_MAX) ? cnt : cnt + IDLE_WIDTH'(1);
    take   = ctl.hit && ctl.waiting && (bumped > best_cnt);
  end

  // Running best
  always_ff @(posedge clk) begin
    if (rst) begin
      stat     <= '0;
      best_cnt <= '0;
    end else if (ctl.clr) begin
      stat.found <= 1'b0;
      best_cnt   <= '0;
    end else if (take) begin
      stat.found    <= 1'b1;
      stat.best_idx <= ctl.idx;
      best_cnt      <= bumped;
    end
  end

endmodule

`default_nettype wire

### tb/sv/aging_two_level_task_picker_tb.sv
// Self-checking testbench for aging_two_level_task_picker: directed and random commands,
// each result checked against a built-in scheduling predictor.
// Depends on atp_pkg and the aging_two_level_task_picker RTL.
`timescale 1ns / 100ps

module aging_two_level_task_picker_tb;
  import atp_pkg::*;

  localparam int NUM_RANDOM = 380;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  aging_two_level_task_picker uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted scheduler state
  logic                  p_live  [NUM_PROCESSES];
  logic                  p_ready [NUM_PROCESSES];
  logic [IDLE_WIDTH-1:0] p_age   [NUM_PROCESSES];
  logic                  t_live  [THR_TOTAL];
  logic                  t_ready [THR_TOTAL];
  logic [IDLE_WIDTH-1:0] t_age   [THR_TOTAL];
  logic                  run_valid;
  logic [3:0]            run_proc;
  logic [2:0]            run_thr;

  cmd_t    cmd_q[$];        // commands waiting to be driven
  result_t sched_q[$];      // predicted results, oldest first
  int      pause_at[$];     // issue counts at which the driver drains first
  int      total_cmds;
  int      cmds_issued;
  int      cmds_accepted;
  int      err_cnt;
  bit      took;

  // Apply one command to the predicted state and return its result
  function automatic result_t schedule_cmd(cmd_t c);
    result_t               r;
    int                    best;
    int                    np;
    int                    nt;
    int                    base;
    logic [IDLE_WIDTH-1:0] best_age;
    logic                  fell;
    r = '0;
    fell = 1'b0;
    case (c.mode)
      MODE_CREATE: begin
        if (!(run_valid && c.proc_id == run_proc && c.thread_id == run_thr)) begin
          if (!p_live[c.proc_id]) begin
            p_live[c.proc_id]  = 1'b1;
            p_ready[c.proc_id] = 1'b1;
            p_age[c.proc_id]   = '0;
          end
          base = c.proc_id * THREADS_PER_PROCESS + c.thread_id;
          t_live[base]  = 1'b1;
          t_ready[base] = 1'b1;
          t_age[base]   = '0;
        end
      end
      MODE_EXIT: begin
        if (run_valid) begin
          p_live[run_proc]  = 1'b0;
          p_ready[run_proc] = 1'b0;
          p_age[run_proc]   = '0;
          for (int t = 0; t < THREADS_PER_PROCESS; t++) begin
            t_live[run_proc * THREADS_PER_PROCESS + t]  = 1'b0;
            t_ready[run_proc * THREADS_PER_PROCESS + t] = 1'b0;
            t_age[run_proc * THREADS_PER_PROCESS + t]   = '0;
          end
          run_valid = 1'b0;
        end
      end
      MODE_TICK: begin
        // age every live process, oldest waiting one wins, lowest index on a tie
        best = -1;
        best_age = '0;
        for (int i = 0; i < NUM_PROCESSES; i++) begin
          if (p_live[i]) begin
            if (p_age[i] != IDLE_MAX) p_age[i] = p_age[i] + 1'b1;
            if (p_ready[i] && p_age[i] > best_age) begin
              best_age = p_age[i];
              best = i;
            end
          end
        end
        np = -1;
        if (best >= 0) begin
          np = best;
        end else if (run_valid) begin
          np = int'(run_proc);
          fell = 1'b1;
        end
        if (np >= 0) begin
          // same rule over the threads of the chosen process
          base = np * THREADS_PER_PROCESS;
          best = -1;
          best_age = '0;
          for (int i = 0; i < THREADS_PER_PROCESS; i++) begin
            if (t_live[base + i]) begin
              if (t_age[base + i] != IDLE_MAX) t_age[base + i] = t_age[base + i] + 1'b1;
              if (t_ready[base + i] && t_age[base + i] > best_age) begin
                best_age = t_age[base + i];
                best = i;
              end
            end
          end
          nt = -1;
          if (best >= 0) begin
            nt = best;
          end else if (run_valid) begin
            nt = int'(run_thr);
            fell = 1'b1;
          end
          if (nt >= 0) begin
            // outgoing entries go back to waiting, incoming ones run
            if (run_valid) begin
              p_ready[run_proc] = 1'b1;
              t_ready[run_proc * THREADS_PER_PROCESS + run_thr] = 1'b1;
            end
            p_age[np]          = '0;
            p_ready[np]        = 1'b0;
            t_age[base + nt]   = '0;
            t_ready[base + nt] = 1'b0;
            run_valid = 1'b1;
            run_proc  = 4'(np);
            run_thr   = 3'(nt);
            r.switched     = 1'b1;
            r.next_process = 4'(np);
            r.pick_thread  = 3'(nt);
            r.fell_back    = fell;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_cmd(logic [1:0] m, logic [3:0] p, logic [2:0] t);
    cmd_t c;
    c.mode      = m;
    c.proc_id   = p;
    c.thread_id = t;
    cmd_q.push_back(c);
  endtask

  // Driver: holds a command until it is taken, then picks the next or idles
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = 0;
    if (!rst && (!start || took)) begin
      if (cmds_issued < total_cmds / 3) idle_pct = 31;
      else if (cmds_issued < (2 * total_cmds) / 3) idle_pct = 68;
      if (pause_at.size() != 0 && cmds_issued == pause_at[0] && sched_q.size() == 0)
        void'(pause_at.pop_front());
      if (cmd_q.size() == 0 || $urandom_range(0, 99) < idle_pct ||
          (pause_at.size() != 0 && cmds_issued == pause_at[0])) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        cmd   <= cmd_q.pop_front();
        cmds_issued++;
      end
    end
    took = 1'b0;
  end

  // Monitor: check strobed results, then predict for an accepted transfer
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (sched_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: sw=%0d p=%0d t=%0d fb=%0d", result.switched,
                     result.next_process, result.pick_thread, result.fell_back);
        end else begin
          want = sched_q.pop_front();
          if (result.switched !== want.switched || result.next_process !== want.next_process ||
              result.pick_thread !== want.pick_thread || result.fell_back !== want.fell_back) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch sw/p/t/fb: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.switched, want.next_process, want.pick_thread, want.fell_back,
                       result.switched, result.next_process, result.pick_thread,
                       result.fell_back);
          end
        end
      end
      if (start && !busy) begin
        sched_q.push_back(schedule_cmd(cmd));
        cmds_accepted++;
        took = 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int sel;
    int p;
    for (int i = 0; i < NUM_PROCESSES; i++) begin
      p_live[i]  = 1'b0;
      p_ready[i] = 1'b0;
      p_age[i]   = '0;
    end
    for (int i = 0; i < THR_TOTAL; i++) begin
      t_live[i]  = 1'b0;
      t_ready[i] = 1'b0;
      t_age[i]   = '0;
    end
    run_valid = 1'b0;
    run_proc  = '0;
    run_thr   = '0;
    cmds_issued = 0;
    cmds_accepted = 0;
    err_cnt = 0;
    took = 1'b0;

    // Directed: empty tick, exit with nothing running, unused mode
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_EXIT, 4'd15, 3'd7);
    queue_cmd(MODE_UNUSED, 4'd15, 3'd7);
    // creates at both ends, second thread on an existing process
    queue_cmd(MODE_CREATE, 4'd15, 3'd7);
    queue_cmd(MODE_CREATE, 4'd0, 3'd0);
    queue_cmd(MODE_CREATE, 4'd0, 3'd7);
    // tie goes to the lowest index, then create on the running thread
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_CREATE, 4'd0, 3'd0);
    queue_cmd(MODE_TICK, 4'd15, 3'd7);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    // exit twice, then the only process falls back on process and thread
    queue_cmd(MODE_EXIT, 4'd0, 3'd0);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_EXIT, 4'd0, 3'd0);
    queue_cmd(MODE_CREATE, 4'd5, 3'd3);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_TICK, 4'd10, 3'd5);
    // second thread on the running process, then a new process
    queue_cmd(MODE_CREATE, 4'd5, 3'd4);
    queue_cmd(MODE_CREATE, 4'd10, 3'd2);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_TICK, 4'd0, 3'd0);
    queue_cmd(MODE_EXIT, 4'd0, 3'd0);
    pause_at.push_back(cmd_q.size());

    // Random: mostly creates and ticks, some exits and unused codes
    for (int i = 0; i < NUM_RANDOM; i++) begin
      sel = $urandom_range(0, 99);
      p = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      if (sel < 45)
        queue_cmd(MODE_CREATE, 4'(p), 3'($urandom_range(0, 7)));
      else if (sel < 85)
        queue_cmd(MODE_TICK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      else if (sel < 95)
        queue_cmd(MODE_EXIT, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      else
        queue_cmd(MODE_UNUSED, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
    end
    total_cmds = cmd_q.size();
    pause_at.push_back((2 * total_cmds) / 3);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (cmds_accepted < total_cmds) @(posedge clk);
    while (sched_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0)
      $display("aging_two_level_task_picker regression: pass");
    else
      $display("aging_two_level_task_picker regression: fail");
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("aging_two_level_task_picker regression: fail");
    $finish;
  end

endmodule
